// ===== src/pmbst_pkg.sv =====
// Shared types, codes and the PEC function of the PMBus slave transaction engine.
`timescale 1ns / 1ps

package pmbst_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int SLOTS_DEF        = 64;
    localparam int ENTRY_BYTES_DEF  = 48;

    localparam logic [7:0] C_CRC_POLY  = 8'h07;
    localparam logic [7:0] C_FILL_BYTE = 8'hFF;
    localparam logic [6:0] C_RC_MAX    = 7'd127;

    localparam logic [2:0] CMD_ADDR_WR   = 3'd0;
    localparam logic [2:0] CMD_DATA_WR   = 3'd1;
    localparam logic [2:0] CMD_ADDR_RD   = 3'd2;
    localparam logic [2:0] CMD_RD_REQ    = 3'd3;
    localparam logic [2:0] CMD_LOAD_DESC = 3'd4;
    localparam logic [2:0] CMD_LOAD_DATA = 3'd5;

    localparam logic [1:0] K_ACK     = 2'd0;
    localparam logic [1:0] K_TX      = 2'd1;
    localparam logic [1:0] K_PAYLOAD = 2'd2;

    localparam logic [1:0] F_NONE    = 2'd0;
    localparam logic [1:0] F_INVALID = 2'd1;
    localparam logic [1:0] F_PEC     = 2'd2;
    localparam logic [1:0] F_COMM    = 2'd3;

    typedef enum logic [2:0] {
        OP_ADDR_WR,
        OP_DATA_WR,
        OP_ADDR_RD,
        OP_RD_REQ,
        OP_LOAD_DESC,
        OP_LOAD_DATA,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx;
        logic [5:0] slot;
        logic [5:0] esize;
        logic       rd;
        logic       wr;
        logic       blk;
        logic [5:0] offset;
        logic       slot_ok;
        logic       off_ok;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_MAP,
        S_DESC,
        S_WR_RD,
        S_WR_EMIT,
        S_CP_RD,
        S_CP_WR,
        S_CP_END,
        S_RQ_DATA,
        S_EMIT
    } t_state;

    function automatic logic [7:0] f_crc8(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        begin
            c = crc ^ b;
            for (int i = 0; i < 8; i++) begin
                c = c[7] ? ((c << 1) ^ C_CRC_POLY) : (c << 1);
            end
            return c;
        end
    endfunction

endpackage

// ===== src/pmbst_front.sv =====
// Front end: accepts bus and load events, classifies them and queues them for the engine.
`timescale 1ns / 1ps

module pmbst_front #(
    parameter int SLOTS       = pmbst_pkg::SLOTS_DEF,
    parameter int ENTRY_BYTES = pmbst_pkg::ENTRY_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_cmd,
    input  logic [7:0]         i_rx_byte,
    input  logic [5:0]         i_slot,
    input  logic [5:0]         i_entry_size,
    input  logic               i_is_readable,
    input  logic               i_is_writable,
    input  logic               i_is_block,
    input  logic [5:0]         i_byte_offset,
    output logic               o_q_valid,
    output pmbst_pkg::t_item   o_q_item,
    input  logic               i_q_pop
);

    pmbst_pkg::t_item w_item;
    pmbst_pkg::t_item r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;

    always_comb begin
        w_item.rx      = i_rx_byte;
        w_item.slot    = i_slot;
        w_item.esize   = (i_entry_size > 6'(ENTRY_BYTES)) ? 6'(ENTRY_BYTES) : i_entry_size;
        w_item.rd      = i_is_readable;
        w_item.wr      = i_is_writable;
        w_item.blk     = i_is_block;
        w_item.offset  = i_byte_offset;
        w_item.slot_ok = 9'(i_slot) < 9'(SLOTS);
        w_item.off_ok  = 9'(i_byte_offset) < 9'(ENTRY_BYTES);
        unique case (i_cmd)
            pmbst_pkg::CMD_ADDR_WR:   w_item.op = pmbst_pkg::OP_ADDR_WR;
            pmbst_pkg::CMD_DATA_WR:   w_item.op = pmbst_pkg::OP_DATA_WR;
            pmbst_pkg::CMD_ADDR_RD:   w_item.op = pmbst_pkg::OP_ADDR_RD;
            pmbst_pkg::CMD_RD_REQ:    w_item.op = pmbst_pkg::OP_RD_REQ;
            pmbst_pkg::CMD_LOAD_DESC: w_item.op = pmbst_pkg::OP_LOAD_DESC;
            pmbst_pkg::CMD_LOAD_DATA: w_item.op = pmbst_pkg::OP_LOAD_DATA;
            default:                  w_item.op = pmbst_pkg::OP_NOP;
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

// ===== src/pmbst_back.sv =====
// Back end: command table, data store, transfer buffer, PEC and the transaction sequencer.
`timescale 1ns / 1ps

module pmbst_back #(
    parameter int BUFFER_BYTES = pmbst_pkg::BUFFER_BYTES_DEF,
    parameter int SLOTS        = pmbst_pkg::SLOTS_DEF,
    parameter int ENTRY_BYTES  = pmbst_pkg::ENTRY_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  pmbst_pkg::t_item i_q_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data,
    output logic [7:0]       o_code,
    output logic [5:0]       o_payload_len,
    output logic             o_last,
    output logic [1:0]       o_fault,
    output logic             o_in_error
);

    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DSD  = SLOTS * ENTRY_BYTES;
    localparam int DAW  = (DSD > 1) ? $clog2(DSD) : 1;
    localparam int BD   = BUFFER_BYTES + ENTRY_BYTES;
    localparam int BAW  = $clog2(BD);
    localparam int WCW  = $clog2(BUFFER_BYTES + 1);
    localparam int CMPW = (WCW > 7) ? WCW : 7;

    pmbst_pkg::t_state r_state, n_state;
    pmbst_pkg::t_item  r_item;

    logic [7:0]     r_crc, n_crc;
    logic [WCW-1:0] r_wc, n_wc;
    logic [6:0]     r_rc, n_rc;
    logic           r_err, n_err;
    logic [7:0]     r_code, n_code;
    logic [SW-1:0]  r_slot, n_slot;
    logic [5:0]     r_size, n_size;
    logic           r_rd, n_rd;
    logic           r_wr, n_wr;
    logic           r_blk, n_blk;
    logic [5:0]     r_idx, n_idx;
    logic [7:0]     r_first, n_first;
    logic [1:0]     r_pk, n_pk;
    logic [7:0]     r_pd, n_pd;
    logic [5:0]     r_pl, n_pl;
    logic [1:0]     r_pf, n_pf;

    logic           r_ov;
    logic [1:0]     r_okind;
    logic [7:0]     r_odata;
    logic [7:0]     r_ocode;
    logic [5:0]     r_opl;
    logic           r_olast;
    logic [1:0]     r_ofault;
    logic           r_oerr;

    // Command table with one valid bit per code, cleared at reset.
    logic [SW-1:0]  mem_map [256];
    logic [255:0]   r_mv;
    logic [SW-1:0]  r_map_rd;
    logic           r_mvr;
    logic           map_re, map_we;

    logic [8:0]     mem_desc [SLOTS];
    logic [8:0]     r_desc_rd;
    logic           desc_re, desc_we;
    logic [8:0]     desc_wdata;

    logic [7:0]     mem_ds [DSD];
    logic [7:0]     r_ds_rd;
    logic           ds_re, ds_we;
    logic [DAW-1:0] ds_raddr, ds_waddr;

    logic [7:0]     mem_wb [BD];
    logic [7:0]     r_wb_rd;
    logic           wb_re, wb_we;
    logic [BAW-1:0] wb_raddr, wb_waddr;
    logic [7:0]     wb_wdata;

    logic           w_ocan;
    logic           w_oload;
    logic [1:0]     w_okind;
    logic [7:0]     w_odata;
    logic [5:0]     w_opl;
    logic           w_olast;
    logic [1:0]     w_ofault;

    logic [1:0]     w_off;
    logic [6:0]     w_thr;
    logic           w_full;
    logic           w_done;
    logic           w_last_idx;
    logic           w_rc_lt;
    logic [6:0]     w_rc_inc;
    logic [7:0]     w_tx_rd;

    assign w_ocan     = !r_ov || !i_stall;
    assign w_off      = r_blk ? 2'd2 : 2'd1;
    assign w_thr      = 7'(r_size) + 7'(w_off);
    assign w_full     = CMPW'(r_wc) >= CMPW'(BUFFER_BYTES);
    assign w_done     = CMPW'(r_wc) >= CMPW'(w_thr);
    assign w_last_idx = (r_idx == (r_size - 6'd1));
    assign w_rc_lt    = r_rc < 7'(r_size);
    assign w_rc_inc   = (r_rc < pmbst_pkg::C_RC_MAX) ? (r_rc + 7'd1) : r_rc;
    assign w_tx_rd    = r_blk ? 8'(r_size) : r_first;
    assign o_q_pop    = (r_state == pmbst_pkg::S_IDLE) && i_q_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmbst_pkg::S_IDLE: begin
                if (i_q_valid) n_state = pmbst_pkg::S_DISP;
            end
            pmbst_pkg::S_DISP: begin
                n_state = pmbst_pkg::S_EMIT;
                case (r_item.op)
                    pmbst_pkg::OP_DATA_WR: begin
                        if (!r_err) begin
                            if (r_wc == '0) begin
                                n_state = pmbst_pkg::S_MAP;
                            end else if (r_wr && !w_full && w_done &&
                                         r_crc == r_item.rx && r_size != 6'd0) begin
                                n_state = pmbst_pkg::S_WR_RD;
                            end
                        end
                    end
                    pmbst_pkg::OP_ADDR_RD: begin
                        if (!r_err && r_rd && r_size != 6'd0) n_state = pmbst_pkg::S_CP_RD;
                    end
                    pmbst_pkg::OP_RD_REQ: begin
                        if (!r_err && w_rc_lt) n_state = pmbst_pkg::S_RQ_DATA;
                    end
                    default: n_state = pmbst_pkg::S_EMIT;
                endcase
            end
            pmbst_pkg::S_MAP:     n_state = r_mvr ? pmbst_pkg::S_DESC : pmbst_pkg::S_EMIT;
            pmbst_pkg::S_DESC:    n_state = pmbst_pkg::S_EMIT;
            pmbst_pkg::S_WR_RD:   n_state = pmbst_pkg::S_WR_EMIT;
            pmbst_pkg::S_WR_EMIT: begin
                if (w_ocan) n_state = w_last_idx ? pmbst_pkg::S_IDLE : pmbst_pkg::S_WR_RD;
            end
            pmbst_pkg::S_CP_RD:   n_state = pmbst_pkg::S_CP_WR;
            pmbst_pkg::S_CP_WR:   n_state = w_last_idx ? pmbst_pkg::S_CP_END : pmbst_pkg::S_CP_RD;
            pmbst_pkg::S_CP_END:  n_state = pmbst_pkg::S_EMIT;
            pmbst_pkg::S_RQ_DATA: n_state = pmbst_pkg::S_EMIT;
            pmbst_pkg::S_EMIT: begin
                if (w_ocan) n_state = pmbst_pkg::S_IDLE;
            end
            default: n_state = pmbst_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_crc = r_crc;   n_wc = r_wc;     n_rc = r_rc;     n_err = r_err;
        n_code = r_code; n_slot = r_slot; n_size = r_size;
        n_rd = r_rd;     n_wr = r_wr;     n_blk = r_blk;
        n_idx = r_idx;   n_first = r_first;
        n_pk = r_pk;     n_pd = r_pd;     n_pl = r_pl;     n_pf = r_pf;
        map_re = 1'b0;   map_we = 1'b0;
        desc_re = 1'b0;  desc_we = 1'b0;
        desc_wdata = {r_item.blk, r_item.wr, r_item.rd, r_item.esize};
        ds_re = 1'b0;    ds_we = 1'b0;
        ds_raddr = DAW'(DAW'(r_slot) * DAW'(ENTRY_BYTES) + DAW'(r_idx));
        ds_waddr = DAW'(DAW'(r_item.slot) * DAW'(ENTRY_BYTES) + DAW'(r_item.offset));
        wb_re = 1'b0;    wb_we = 1'b0;
        wb_raddr = BAW'(r_idx) + BAW'(w_off);
        wb_waddr = BAW'(r_wc);
        wb_wdata = r_item.rx;
        w_oload = 1'b0;
        w_okind = r_pk;  w_odata = r_pd;  w_opl = r_pl;
        w_olast = 1'b1;  w_ofault = r_pf;

        unique case (r_state)
            pmbst_pkg::S_DISP: begin
                n_pk = pmbst_pkg::K_ACK;
                n_pd = 8'd0;
                n_pl = 6'd0;
                n_pf = pmbst_pkg::F_NONE;
                case (r_item.op)
                    pmbst_pkg::OP_ADDR_WR: begin
                        n_crc    = pmbst_pkg::f_crc8(8'd0, r_item.rx);
                        wb_we    = 1'b1;
                        wb_waddr = '0;
                        wb_wdata = 8'd0;
                        n_err    = 1'b0;
                        n_rc     = 7'd0;
                        n_wc     = '0;
                    end
                    pmbst_pkg::OP_DATA_WR: begin
                        if (!r_err) begin
                            if (r_wc == '0) begin
                                map_re = 1'b1;
                            end else if (!r_wr || w_full) begin
                                n_pf  = pmbst_pkg::F_INVALID;
                                n_err = 1'b1;
                            end else if (w_done && r_crc != r_item.rx) begin
                                n_pf  = pmbst_pkg::F_PEC;
                                n_err = 1'b1;
                            end else begin
                                // Send byte: a sized-zero command completes with one result.
                                if (w_done && r_size == 6'd0) n_pk = pmbst_pkg::K_PAYLOAD;
                                n_idx = 6'd0;
                                wb_we = 1'b1;
                                n_crc = pmbst_pkg::f_crc8(r_crc, r_item.rx);
                                n_wc  = WCW'(r_wc + 1'b1);
                            end
                        end
                    end
                    pmbst_pkg::OP_ADDR_RD: begin
                        n_pk = pmbst_pkg::K_TX;
                        n_pd = pmbst_pkg::C_FILL_BYTE;
                        if (!r_err) begin
                            n_crc = pmbst_pkg::f_crc8(r_crc, r_item.rx);
                            n_idx = 6'd0;
                            if (!r_rd || r_size == 6'd0) begin
                                n_pf  = pmbst_pkg::F_COMM;
                                n_err = 1'b1;
                            end
                        end
                    end
                    pmbst_pkg::OP_RD_REQ: begin
                        n_pk = pmbst_pkg::K_TX;
                        n_pd = pmbst_pkg::C_FILL_BYTE;
                        wb_raddr = BAW'(r_rc);
                        if (!r_err) begin
                            if (w_rc_lt) begin
                                wb_re = 1'b1;
                            end else if (r_rc == 7'(r_size)) begin
                                n_pd  = r_crc;
                                n_crc = pmbst_pkg::f_crc8(r_crc, r_crc);
                                n_rc  = w_rc_inc;
                            end else begin
                                n_pf  = pmbst_pkg::F_COMM;
                                n_err = 1'b1;
                                n_crc = pmbst_pkg::f_crc8(r_crc, pmbst_pkg::C_FILL_BYTE);
                                n_rc  = w_rc_inc;
                            end
                        end
                    end
                    pmbst_pkg::OP_LOAD_DESC: begin
                        if (r_item.slot_ok) begin
                            map_we  = 1'b1;
                            desc_we = 1'b1;
                        end
                    end
                    pmbst_pkg::OP_LOAD_DATA: begin
                        if (r_item.slot_ok && r_item.off_ok) ds_we = 1'b1;
                    end
                    default: n_pk = pmbst_pkg::K_ACK;
                endcase
            end
            pmbst_pkg::S_MAP: begin
                n_code = r_item.rx;
                n_wc   = WCW'(r_wc + 1'b1);
                if (r_mvr) begin
                    desc_re = 1'b1;
                end else begin
                    n_pf  = pmbst_pkg::F_INVALID;
                    n_err = 1'b1;
                end
            end
            pmbst_pkg::S_DESC: begin
                n_slot = r_map_rd;
                n_size = r_desc_rd[5:0];
                n_rd   = r_desc_rd[6];
                n_wr   = r_desc_rd[7];
                n_blk  = r_desc_rd[8];
                n_crc  = pmbst_pkg::f_crc8(r_crc, r_item.rx);
            end
            pmbst_pkg::S_WR_RD: begin
                wb_re = 1'b1;
            end
            pmbst_pkg::S_WR_EMIT: begin
                w_okind  = pmbst_pkg::K_PAYLOAD;
                w_odata  = r_wb_rd;
                w_opl    = r_size;
                w_olast  = w_last_idx;
                w_ofault = pmbst_pkg::F_NONE;
                if (w_ocan) begin
                    w_oload = 1'b1;
                    n_idx   = r_idx + 6'd1;
                end
            end
            pmbst_pkg::S_CP_RD: begin
                ds_re = 1'b1;
            end
            pmbst_pkg::S_CP_WR: begin
                wb_we    = 1'b1;
                wb_waddr = BAW'(r_idx);
                wb_wdata = r_ds_rd;
                if (r_idx == 6'd0) n_first = r_ds_rd;
                if (!w_last_idx) n_idx = r_idx + 6'd1;
            end
            pmbst_pkg::S_CP_END: begin
                n_pd  = w_tx_rd;
                n_rc  = r_blk ? 7'd0 : 7'd1;
                n_crc = pmbst_pkg::f_crc8(r_crc, w_tx_rd);
            end
            pmbst_pkg::S_RQ_DATA: begin
                n_pd  = r_wb_rd;
                n_crc = pmbst_pkg::f_crc8(r_crc, r_wb_rd);
                n_rc  = w_rc_inc;
            end
            pmbst_pkg::S_EMIT: begin
                w_oload = w_ocan;
            end
            default: w_oload = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) mem_map[r_item.rx] <= SW'(r_item.slot);
        if (map_re) begin
            r_map_rd <= mem_map[r_item.rx];
            r_mvr    <= r_mv[r_item.rx];
        end
        if (desc_we) mem_desc[SW'(r_item.slot)] <= desc_wdata;
        if (desc_re) r_desc_rd <= mem_desc[r_map_rd];
        if (ds_we) mem_ds[ds_waddr] <= r_item.rx;
        if (ds_re) r_ds_rd <= mem_ds[ds_raddr];
        if (wb_we) mem_wb[wb_waddr] <= wb_wdata;
        if (wb_re) r_wb_rd <= mem_wb[wb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_item <= i_q_item;
        r_idx   <= n_idx;   r_first <= n_first;
        r_pk    <= n_pk;    r_pd   <= n_pd;   r_pl   <= n_pl;   r_pf <= n_pf;
        if (w_oload) begin
            r_okind  <= w_okind;
            r_odata  <= w_odata;
            r_ocode  <= r_code;
            r_opl    <= w_opl;
            r_olast  <= w_olast;
            r_ofault <= w_ofault;
            r_oerr   <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmbst_pkg::S_IDLE;
            r_crc   <= 8'd0;
            r_wc    <= '0;
            r_rc    <= 7'd0;
            r_err   <= 1'b0;
            r_mv    <= '0;
            r_ov    <= 1'b0;
            r_code  <= 8'd0;
            r_slot  <= '0;
            r_size  <= 6'd0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
            r_blk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_crc   <= n_crc;
            r_wc    <= n_wc;
            r_rc    <= n_rc;
            r_err   <= n_err;
            r_code  <= n_code;
            r_slot  <= n_slot;
            r_size  <= n_size;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_blk   <= n_blk;
            if (map_we) r_mv[r_item.rx] <= 1'b1;
            if (w_oload) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_kind        = r_okind;
    assign o_data        = r_odata;
    assign o_code        = r_ocode;
    assign o_payload_len = r_opl;
    assign o_last        = r_olast;
    assign o_fault       = r_ofault;
    assign o_in_error    = r_oerr;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == pmbst_pkg::S_IDLE) && i_q_valid)
        else $error("queue popped outside idle");
    a_wc_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_wc) <= CMPW'(BUFFER_BYTES))
        else $error("write count past buffer size");
    a_sweep_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmbst_pkg::S_WR_EMIT || r_state == pmbst_pkg::S_CP_WR)
        |-> (r_idx < r_size))
        else $error("sweep index past command size");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmbst_pkg::S_EMIT && w_ocan) |=> r_ov && r_olast)
        else $error("final result not marked last");

endmodule

// ===== src/pmbus_slave_transaction_engine_unit.sv =====
// Top level of the PMBus slave transaction engine: front queue and back sequencer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  input   | in        | i_valid / o_stall  | cmd, rx_byte, slot, entry_size, flags, offset
//  result  | out       | o_valid / i_stall  | kind, data, code, payload_len, last, fault,
//          |           |                    | in_error
//
// An item passes through dequeue, dispatch and result states; the result waits out a stall.
// The first command byte adds table and descriptor read states, or only the table read
// when its code is unsupported. A read address item copies the slot into the transfer
// buffer with a read and a write state per byte, then an end state; a read request from
// the buffer adds a buffer read state. A completed write emits its payload through the
// buffer read port with a read and an emit state per byte. Reset is synchronous and
// clears the command table valid bits at once, so no clearing pass is needed. A two-entry
// queue keeps input accepted while the back end waits on a stalled result.
`timescale 1ns / 1ps

module pmbus_slave_transaction_engine_unit #(
    parameter int BUFFER_BYTES = pmbst_pkg::BUFFER_BYTES_DEF,
    parameter int SLOTS        = pmbst_pkg::SLOTS_DEF,
    parameter int ENTRY_BYTES  = pmbst_pkg::ENTRY_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_rx_byte,
    input  logic [5:0] i_slot,
    input  logic [5:0] i_entry_size,
    input  logic       i_is_readable,
    input  logic       i_is_writable,
    input  logic       i_is_block,
    input  logic [5:0] i_byte_offset,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic [7:0] o_code,
    output logic [5:0] o_payload_len,
    output logic       o_last,
    output logic [1:0] o_fault,
    output logic       o_in_error
);

    logic             q_valid;
    logic             q_pop;
    pmbst_pkg::t_item q_item;

    pmbst_front #(
        .SLOTS       (SLOTS),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_rx_byte     (i_rx_byte),
        .i_slot        (i_slot),
        .i_entry_size  (i_entry_size),
        .i_is_readable (i_is_readable),
        .i_is_writable (i_is_writable),
        .i_is_block    (i_is_block),
        .i_byte_offset (i_byte_offset),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    pmbst_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .SLOTS        (SLOTS),
        .ENTRY_BYTES  (ENTRY_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_data        (o_data),
        .o_code        (o_code),
        .o_payload_len (o_payload_len),
        .o_last        (o_last),
        .o_fault       (o_fault),
        .o_in_error    (o_in_error)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the PMBus slave transaction engine with a built-in predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int BUF_BYTES  = 64;
    localparam int NSLOTS     = 64;
    localparam int ENT_BYTES  = 48;
    localparam int RAND_ITEMS = 160;
    localparam int TAIL_ITEMS = 55;
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] rx;
        logic [5:0] slot;
        logic [5:0] esize;
        logic       rd;
        logic       wr;
        logic       blk;
        logic [5:0] off;
    } t_bus_item;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] code;
        logic [5:0] plen;
        logic       last;
        logic [1:0] fault;
        logic       in_err;
    } t_engine_res;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [2:0] i_cmd = '0;
    logic [7:0] i_rx_byte = '0;
    logic [5:0] i_slot = '0;
    logic [5:0] i_entry_size = '0;
    logic       i_is_readable = 1'b0;
    logic       i_is_writable = 1'b0;
    logic       i_is_block = 1'b0;
    logic [5:0] i_byte_offset = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_data;
    logic [7:0] o_code;
    logic [5:0] o_payload_len;
    logic       o_last;
    logic [1:0] o_fault;
    logic       o_in_error;

    pmbus_slave_transaction_engine_unit dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state of the engine.
    logic       map_ok [256];
    logic [5:0] map_slot [256];
    logic [5:0] desc_size [NSLOTS];
    logic       desc_rd [NSLOTS];
    logic       desc_wr [NSLOTS];
    logic       desc_blk [NSLOTS];
    logic [7:0] store [NSLOTS][ENT_BYTES];
    logic       loaded [NSLOTS][ENT_BYTES];
    logic [7:0] xbuf [BUF_BYTES + ENT_BYTES];
    logic       xbuf_set [BUF_BYTES + ENT_BYTES];
    logic [7:0] pec;
    int         wcount;
    int         rcount;
    logic       err_flag;
    logic [7:0] cur_code;
    logic [5:0] cur_slot;
    int         cur_size;
    logic       cur_rd, cur_wr, cur_blk;

    t_bus_item   pending_items[$];
    t_engine_res expected_results[$];
    logic [7:0]  code_pool[$];
    int          errors = 0;
    int          cycles = 0;
    int          gen_count = 0;

    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
        return c;
    endfunction

    task automatic predict_engine(input t_bus_item it);
        t_engine_res outs[$];
        t_engine_res r;
        logic [1:0] fault;
        logic [1:0] kind;
        logic [7:0] tx;
        int ofs, sz;
        fault = pmbst_pkg::F_NONE;
        kind = pmbst_pkg::K_ACK;
        tx = 8'h00;
        case (it.cmd)
            pmbst_pkg::CMD_ADDR_WR: begin
                pec = crc_next(8'h00, it.rx);
                xbuf[0] = 8'h00;
                xbuf_set[0] = 1'b1;
                err_flag = 1'b0;
                rcount = 0;
                wcount = 0;
            end
            pmbst_pkg::CMD_DATA_WR: begin
                if (!err_flag) begin
                    if (wcount != 0) begin
                        ofs = cur_blk ? 2 : 1;
                        if (!cur_wr || wcount >= BUF_BYTES) begin
                            fault = pmbst_pkg::F_INVALID;
                            err_flag = 1'b1;
                        end else if (wcount >= cur_size + ofs && pec != it.rx) begin
                            fault = pmbst_pkg::F_PEC;
                            err_flag = 1'b1;
                        end else begin
                            if (wcount >= cur_size + ofs) begin
                                r = '{pmbst_pkg::K_PAYLOAD, 8'h00, cur_code, 6'd0, 1'b0,
                                      pmbst_pkg::F_NONE, 1'b0};
                                if (cur_size == 0) outs.push_back(r);
                                for (int i = 0; i < cur_size; i++) begin
                                    r.data = xbuf[i + ofs];
                                    r.plen = cur_size[5:0];
                                    outs.push_back(r);
                                end
                            end
                            xbuf[wcount] = it.rx;
                            xbuf_set[wcount] = 1'b1;
                            pec = crc_next(pec, it.rx);
                            wcount++;
                        end
                    end else begin
                        cur_code = it.rx;
                        if (!map_ok[it.rx]) begin
                            fault = pmbst_pkg::F_INVALID;
                            err_flag = 1'b1;
                        end else begin
                            cur_slot = map_slot[it.rx];
                            cur_size = desc_size[cur_slot];
                            cur_rd = desc_rd[cur_slot];
                            cur_wr = desc_wr[cur_slot];
                            cur_blk = desc_blk[cur_slot];
                            pec = crc_next(pec, it.rx);
                        end
                        wcount++;
                    end
                end
            end
            pmbst_pkg::CMD_ADDR_RD: begin
                kind = pmbst_pkg::K_TX;
                tx = pmbst_pkg::C_FILL_BYTE;
                if (!err_flag) begin
                    pec = crc_next(pec, it.rx);
                    if (!cur_rd || cur_size == 0) begin
                        fault = pmbst_pkg::F_COMM;
                        err_flag = 1'b1;
                    end else begin
                        for (int i = 0; i < cur_size; i++) begin
                            xbuf[i] = store[cur_slot][i];
                            xbuf_set[i] = 1'b1;
                        end
                        if (cur_blk) begin
                            tx = cur_size[7:0];
                            rcount = 0;
                        end else begin
                            tx = xbuf[0];
                            rcount = 1;
                        end
                        pec = crc_next(pec, tx);
                    end
                end
            end
            pmbst_pkg::CMD_RD_REQ: begin
                kind = pmbst_pkg::K_TX;
                tx = pmbst_pkg::C_FILL_BYTE;
                if (!err_flag) begin
                    if (rcount < cur_size) tx = xbuf[rcount];
                    else if (rcount == cur_size) tx = pec;
                    else begin
                        fault = pmbst_pkg::F_COMM;
                        err_flag = 1'b1;
                    end
                    if (rcount < 127) rcount++;
                    pec = crc_next(pec, tx);
                end
            end
            pmbst_pkg::CMD_LOAD_DESC: begin
                sz = (it.esize > ENT_BYTES) ? ENT_BYTES : it.esize;
                map_ok[it.rx] = 1'b1;
                map_slot[it.rx] = it.slot;
                desc_size[it.slot] = sz[5:0];
                desc_rd[it.slot] = it.rd;
                desc_wr[it.slot] = it.wr;
                desc_blk[it.slot] = it.blk;
            end
            pmbst_pkg::CMD_LOAD_DATA: begin
                if (it.off < ENT_BYTES) begin
                    store[it.slot][it.off] = it.rx;
                    loaded[it.slot][it.off] = 1'b1;
                end
            end
            default: ;
        endcase
        if (outs.size() == 0) outs.push_back('{kind, tx, cur_code, 6'd0, 1'b0, fault, 1'b0});
        outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) begin
            outs[i].in_err = err_flag;
            expected_results.push_back(outs[i]);
        end
    endtask

    task automatic queue_item(input t_bus_item it);
        predict_engine(it);
        pending_items.push_back(it);
        gen_count++;
    endtask

    task automatic queue_bus(input logic [2:0] cmd, input logic [7:0] rx);
        t_bus_item it;
        it = '{cmd, rx, 6'($urandom), 6'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom), 6'($urandom)};
        // A read request must not fetch a buffer byte that nothing has written yet.
        if (cmd == pmbst_pkg::CMD_RD_REQ && !err_flag && rcount < cur_size &&
            !xbuf_set[rcount]) return;
        // A read address copies the slot, so every byte it copies must hold loaded data.
        if (cmd == pmbst_pkg::CMD_ADDR_RD && !err_flag && cur_rd && cur_size != 0) begin
            for (int i = 0; i < cur_size; i++) begin
                if (!loaded[cur_slot][i]) begin
                    queue_item('{pmbst_pkg::CMD_LOAD_DATA, 8'($urandom), cur_slot,
                                 6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                                 6'(i)});
                end
            end
        end
        queue_item(it);
    endtask

    task automatic queue_desc(input logic [7:0] code, input logic [5:0] slot,
                              input logic [5:0] size, input logic rd, input logic wr,
                              input logic blk);
        queue_item('{pmbst_pkg::CMD_LOAD_DESC, code, slot, size, rd, wr, blk, 6'($urandom)});
        code_pool.push_back(code);
    endtask

    // mode: 0 correct PEC, 1 bad PEC, 2 short, 3 extra bytes after the PEC.
    task automatic write_transfer(input logic [7:0] code, input int mode);
        int nbytes;
        queue_bus(pmbst_pkg::CMD_ADDR_WR, {7'($urandom), 1'b0});
        queue_bus(pmbst_pkg::CMD_DATA_WR, code);
        nbytes = cur_size + (cur_blk ? 1 : 0);
        if (mode == 2) nbytes = $urandom_range(0, nbytes);
        for (int i = 0; i < nbytes; i++) begin
            if (cur_blk && i == 0) queue_bus(pmbst_pkg::CMD_DATA_WR, cur_size[7:0]);
            else queue_bus(pmbst_pkg::CMD_DATA_WR, 8'($urandom));
        end
        if (mode != 2) queue_bus(pmbst_pkg::CMD_DATA_WR, (mode == 1) ? (pec ^ 8'h01) : pec);
        if (mode == 3) begin
            for (int i = $urandom_range(1, 3); i > 0; i--) begin
                queue_bus(pmbst_pkg::CMD_DATA_WR,
                          ($urandom_range(0, 1) == 1) ? pec : 8'($urandom));
            end
        end
    endtask

    task automatic read_transfer(input logic [7:0] code, input int extra);
        int nreq;
        queue_bus(pmbst_pkg::CMD_ADDR_WR, {7'($urandom), 1'b0});
        queue_bus(pmbst_pkg::CMD_DATA_WR, code);
        queue_bus(pmbst_pkg::CMD_ADDR_RD, {7'($urandom), 1'b1});
        nreq = cur_size + (cur_blk ? 1 : 0) + extra;
        for (int i = 0; i < nreq; i++) queue_bus(pmbst_pkg::CMD_RD_REQ, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return code_pool[$urandom_range(0, code_pool.size() - 1)];
    endfunction

    initial begin
        t_bus_item rnd_it;
        for (int i = 0; i < 256; i++) map_ok[i] = 1'b0;
        for (int s = 0; s < NSLOTS; s++) begin
            desc_size[s] = '0;
            desc_rd[s] = 1'b0;
            desc_wr[s] = 1'b0;
            desc_blk[s] = 1'b0;
            for (int b = 0; b < ENT_BYTES; b++) loaded[s][b] = 1'b0;
        end
        foreach (xbuf[i]) xbuf[i] = 8'h00;
        foreach (xbuf_set[i]) xbuf_set[i] = 1'b0;
        pec = 8'h00;
        wcount = 0;
        rcount = 0;
        err_flag = 1'b0;
        cur_code = 8'h00;
        cur_slot = '0;
        cur_size = 0;
        {cur_rd, cur_wr, cur_blk} = 3'b000;

        // Directed part: table extremes, send byte, saturated size, faults.
        write_transfer(8'h3e, 0);
        queue_desc(8'h3e, 6'd1, 6'd0, 1'b0, 1'b1, 1'b0);
        queue_desc(8'hFF, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0);
        queue_desc(8'h00, 6'd0, 6'd2, 1'b1, 1'b1, 1'b1);
        queue_desc(8'h20, 6'd2, 6'd1, 1'b1, 1'b0, 1'b0);
        queue_item('{pmbst_pkg::CMD_LOAD_DATA, 8'hA5, 6'd2, 6'd0, 1'b0, 1'b0, 1'b0, 6'd63});
        queue_item('{3'd6, 8'h5A, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 6'd0});
        queue_item('{3'd7, 8'hFF, 6'd63, 6'd63, 1'b1, 1'b1, 1'b1, 6'd47});
        write_transfer(8'h3e, 0);
        write_transfer(8'h00, 1);
        write_transfer(8'h40, 0);
        read_transfer(8'h20, 2);
        write_transfer(8'h20, 0);
        read_transfer(8'h3e, 0);

        // Random part: mostly well-formed transfers with random content.
        while (gen_count < RAND_ITEMS - TAIL_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1: queue_desc(8'($urandom), 6'($urandom_range(0, 7)),
                                 ($urandom_range(0, 3) == 0) ? 6'($urandom) :
                                                                6'($urandom_range(0, 4)),
                                 1'($urandom), 1'($urandom), 1'($urandom));
                2: begin
                    rnd_it = '{3'($urandom), 8'($urandom), 6'($urandom), 6'($urandom),
                               1'($urandom), 1'($urandom), 1'($urandom), 6'($urandom)};
                    if (rnd_it.cmd == pmbst_pkg::CMD_ADDR_RD ||
                        rnd_it.cmd == pmbst_pkg::CMD_RD_REQ) begin
                        queue_bus(rnd_it.cmd, rnd_it.rx);
                    end else begin
                        queue_item(rnd_it);
                    end
                end
                3: queue_bus(3'($urandom_range(0, 3)), 8'($urandom));
                4, 5, 6, 7, 8, 9, 10, 11:
                    write_transfer(pick_code(), ($urandom_range(0, 3) == 0) ?
                                   $urandom_range(1, 3) : 0);
                default: read_transfer(pick_code(), ($urandom_range(0, 2) == 0) ?
                                       $urandom_range(1, 2) : 0);
            endcase
        end
        // A full-size block write gives the longest payload run.
        queue_desc(8'hFF, 6'd63, 6'd48, 1'b1, 1'b1, 1'b1);
        write_transfer(8'hFF, 0);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // Sender: bursts of transfers with random gaps.
    logic in_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_mode = 0;
    int   stall_cnt = 0;
    t_bus_item cur_it;

    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid = 1'b0;
            end else if (pending_items.size() != 0) begin
                cur_it = pending_items.pop_front();
                burst_left--;
                i_cmd = cur_it.cmd;
                i_rx_byte = cur_it.rx;
                i_slot = cur_it.slot;
                i_entry_size = cur_it.esize;
                i_is_readable = cur_it.rd;
                i_is_writable = cur_it.wr;
                i_is_block = cur_it.blk;
                i_byte_offset = cur_it.off;
                i_valid = 1'b1;
            end else begin
                i_valid = 1'b0;
            end
        end
        // The receiver stall pattern changes character over the run.
        if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall = 1'b0;
            1: i_stall = ($urandom_range(0, 2) == 0);
            2: begin
                if (stall_cnt == 0) begin
                    stall_cnt = $urandom_range(1, 12);
                    i_stall = !i_stall;
                end
                stall_cnt--;
            end
            default: i_stall = ($urandom_range(0, 7) != 0);
        endcase
    end

    // Result monitor: compare each transfer with the oldest expectation.
    t_engine_res exp_r;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                exp_r = expected_results.pop_front();
                if (o_kind !== exp_r.kind || o_data !== exp_r.data ||
                    o_code !== exp_r.code || o_payload_len !== exp_r.plen ||
                    o_last !== exp_r.last || o_fault !== exp_r.fault ||
                    o_in_error !== exp_r.in_err) begin
                    report_mismatch($sformatf(
                        "got k%0d d%h c%h l%0d t%0d f%0d e%0d exp k%0d d%h c%h l%0d t%0d f%0d e%0d",
                        o_kind, o_data, o_code, o_payload_len, o_last, o_fault, o_in_error,
                        exp_r.kind, exp_r.data, exp_r.code, exp_r.plen, exp_r.last,
                        exp_r.fault, exp_r.in_err));
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (expected_results.size() != 0) report_mismatch("expected results left over");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
